>>> design/rpr_pkg.sv
// Shared constants and types for the rephasor phase rescaler.
`default_nettype none
package rpr_pkg;

    localparam int PhFracBits = 16;
    localparam int RatioBits  = 8;
    localparam int PhW        = PhFracBits + 1;           // phase width, 0..ONE
    localparam int ScaleW     = RatioBits + PhFracBits;   // Q(RATIO).F scale
    localparam int CorrW      = PhFracBits + 2;           // Q2.F correction
    localparam int DivW       = PhW + PhFracBits;         // widest dividend
    localparam int MulBW      = CorrW;                    // multiplier operand
    localparam int AccW       = (DivW > ScaleW + MulBW) ? DivW : ScaleW + MulBW;
    localparam int CntW       = $clog2(DivW);

    localparam logic [PhW-1:0] PhOne = PhW'(1) << PhFracBits;

    typedef enum logic [1:0] {
        OP_MUL = 2'b01,
        OP_DIV = 2'b10
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DRS  = 8'b0000_0010,
        S_DIS  = 8'b0000_0100,
        S_MUL1 = 8'b0000_1000,
        S_MUL2 = 8'b0001_0000,
        S_MUL3 = 8'b0010_0000,
        S_DCOR = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

>>> design/rpr_serial_alu.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none
module rpr_serial_alu (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rpr_pkg::t_alu_ctl         i_ctl,
    input  wire logic [rpr_pkg::DivW-1:0]  i_a,    // multiplicand (low bits) or dividend
    input  wire logic [rpr_pkg::MulBW-1:0] i_b,    // multiplier or divisor
    output logic                           o_done,
    output logic [rpr_pkg::AccW-1:0]       o_res   // product, or quotient in low bits
);

    localparam int AW = rpr_pkg::ScaleW;
    localparam int BW = rpr_pkg::MulBW;
    localparam int DW = rpr_pkg::DivW;
    localparam int RW = rpr_pkg::PhW + 1;

    logic [rpr_pkg::AccW-1:0] r_acc, n_acc;
    logic [AW-1:0]            r_a;
    logic [BW-1:0]            r_b, n_b;
    logic [RW-1:0]            r_rem, n_rem;
    logic [rpr_pkg::CntW-1:0] r_cnt;
    logic                     r_busy, r_done;
    rpr_pkg::t_op             r_op;

    logic [AW:0]   m_sum;
    logic [RW-1:0] d_sh;

    always_comb begin
        n_acc = r_acc;
        n_b   = r_b;
        n_rem = r_rem;
        m_sum = {1'b0, r_acc[rpr_pkg::AccW-1 -: AW]} + (r_b[0] ? {1'b0, r_a} : '0);
        d_sh  = {r_rem[RW-2:0], r_acc[DW-1]};
        case (r_op)
            rpr_pkg::OP_MUL: begin
                n_acc = {m_sum, r_acc[BW-1:1]};
                n_b   = r_b >> 1;
            end
            rpr_pkg::OP_DIV: begin
                // subtract when the partial remainder covers the divisor
                if (d_sh >= {1'b0, r_b[RW-2:0]}) begin
                    n_rem = d_sh - {1'b0, r_b[RW-2:0]};
                    n_acc = {r_acc[rpr_pkg::AccW-1:DW], r_acc[DW-2:0], 1'b1};
                end else begin
                    n_rem = d_sh;
                    n_acc = {r_acc[rpr_pkg::AccW-1:DW], r_acc[DW-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= rpr_pkg::OP_MUL;
            r_acc  <= '0;
            r_a    <= '0;
            r_b    <= '0;
            r_rem  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_op   <= i_ctl.op;
                r_a    <= i_a[AW-1:0];
                r_b    <= i_b;
                r_rem  <= '0;
                if (i_ctl.op == rpr_pkg::OP_DIV) begin
                    r_acc <= {{(rpr_pkg::AccW-DW){1'b0}}, i_a};
                    r_cnt <= rpr_pkg::CntW'(DW - 1);
                end else begin
                    r_acc <= '0;
                    r_cnt <= rpr_pkg::CntW'(BW - 1);
                end
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= n_b;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule
`default_nettype wire

>>> design/rephasor_phase_rescaler_top.sv
// Rephasor phase rescaler: sequencer and phase state around one serial unit.
// Each request runs the two ratio divides when both ratio fields are nonzero, then three
// multiplies, then the correction divide, which is skipped while the older check phase is
// zero. One request at a time; the next is taken while the result waits at the output.
// Reset (synchronous, active low) zeroes the phases and sets scales and
// correction to 1.0.
`default_nettype none
module rephasor_phase_rescaler_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // ext_phase[16:0], ratio_num[24:17], ratio_den[32:25]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // out_phase[16:0]
    output logic             o_m_axis_tuser    // ratio_error[0]
);

    localparam int PW = rpr_pkg::PhW;
    localparam int SW = rpr_pkg::ScaleW;
    localparam int CW = rpr_pkg::CorrW;
    localparam int RB = rpr_pkg::RatioBits;
    localparam int F  = rpr_pkg::PhFracBits;
    localparam int XW = rpr_pkg::AccW - F;

    localparam logic [PW-1:0] One = rpr_pkg::PhOne;
    localparam logic [XW-1:0] Cap4 = XW'(One) << 2;
    localparam logic [XW-1:0] CapInc = XW'(One) + 1'b1;
    localparam logic [rpr_pkg::DivW-1:0] CorMax = rpr_pkg::DivW'(One) << 1;
    localparam logic [rpr_pkg::DivW-1:0] CorMin = rpr_pkg::DivW'(One) >> 1;

    rpr_pkg::t_state r_state, n_state;
    logic r_go, n_go;

    logic [PW-1:0] r_main, n_main, r_chk0, n_chk0, r_chk1, n_chk1;
    logic [PW-1:0] r_eh0, n_eh0, r_eh1, n_eh1, r_ext, n_ext, r_pc, n_pc;
    logic [PW-1:0] r_einc, n_einc, r_minc, n_minc;
    logic [CW-1:0] r_corr, n_corr;
    logic [SW-1:0] r_rs, n_rs, r_is, n_is;
    logic [PW+2:0] r_x1, n_x1;
    logic [RB-1:0] r_num, n_num, r_den, n_den;
    logic          r_err, n_err;
    logic          r_ov, n_ov;
    logic [PW-1:0] r_oph, n_oph;
    logic          r_oerr, n_oerr;

    rpr_pkg::t_alu_ctl alu_ctl;
    logic [rpr_pkg::DivW-1:0]  alu_a;
    logic [rpr_pkg::MulBW-1:0] alu_b;
    logic                      alu_done;
    logic [rpr_pkg::AccW-1:0]  alu_res;

    logic [PW-1:0] in_ext;
    logic [RB-1:0] in_num, in_den;
    logic          s_acc;
    logic [XW-1:0] res_hi;
    logic [PW:0]   adv_sum;
    logic [PW-1:0] adv_base, adv_out;
    logic [PW:0]   adv_inc;
    logic [rpr_pkg::DivW-1:0] quo;

    rpr_serial_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (alu_ctl),
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_done (alu_done),
        .o_res  (alu_res)
    );

    assign in_ext = (i_s_axis_tdata[PW-1:0] > One) ? One : i_s_axis_tdata[PW-1:0];
    assign in_num = i_s_axis_tdata[PW +: RB];
    assign in_den = i_s_axis_tdata[PW+RB +: RB];

    assign o_s_axis_tready = (r_state == rpr_pkg::S_IDLE);
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    assign res_hi = alu_res[rpr_pkg::AccW-1:F];
    assign quo    = alu_res[rpr_pkg::DivW-1:0];

    // truncated phasor step shared by the main and check phases
    assign adv_base = (r_state == rpr_pkg::S_MUL2) ? r_main : r_chk0;
    assign adv_inc  = (res_hi > CapInc) ? CapInc[PW:0] : res_hi[PW:0];
    assign adv_sum  = {1'b0, adv_base} + adv_inc;
    assign adv_out  = (adv_sum > {1'b0, One}) ? '0 : adv_sum[PW-1:0];

    always_comb begin
        alu_ctl.start = r_go;
        alu_ctl.op    = rpr_pkg::OP_MUL;
        alu_a         = '0;
        alu_b         = '0;
        case (r_state)
            rpr_pkg::S_DRS: begin
                alu_ctl.op = rpr_pkg::OP_DIV;
                alu_a = rpr_pkg::DivW'({r_den, {F{1'b0}}});
                alu_b = rpr_pkg::MulBW'(r_num);
            end
            rpr_pkg::S_DIS: begin
                alu_ctl.op = rpr_pkg::OP_DIV;
                alu_a = rpr_pkg::DivW'({r_num, {F{1'b0}}});
                alu_b = rpr_pkg::MulBW'(r_den);
            end
            rpr_pkg::S_MUL1: begin
                alu_a = rpr_pkg::DivW'(r_rs);
                alu_b = rpr_pkg::MulBW'(r_einc);
            end
            rpr_pkg::S_MUL2: begin
                alu_a = rpr_pkg::DivW'(r_x1);
                alu_b = rpr_pkg::MulBW'(r_corr);
            end
            rpr_pkg::S_MUL3: begin
                alu_a = rpr_pkg::DivW'(r_is);
                alu_b = rpr_pkg::MulBW'(r_minc);
            end
            rpr_pkg::S_DCOR: begin
                alu_ctl.op = rpr_pkg::OP_DIV;
                alu_a = {r_eh1, {F{1'b0}}};
                alu_b = rpr_pkg::MulBW'(r_chk1);
            end
            default: alu_ctl.start = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        n_main  = r_main;
        n_chk0  = r_chk0;
        n_chk1  = r_chk1;
        n_eh0   = r_eh0;
        n_eh1   = r_eh1;
        n_ext   = r_ext;
        n_pc    = r_pc;
        n_einc  = r_einc;
        n_minc  = r_minc;
        n_corr  = r_corr;
        n_rs    = r_rs;
        n_is    = r_is;
        n_x1    = r_x1;
        n_num   = r_num;
        n_den   = r_den;
        n_err   = r_err;
        n_ov    = r_ov;
        n_oph   = r_oph;
        n_oerr  = r_oerr;

        if (r_ov && i_m_axis_tready) n_ov = 1'b0;

        case (r_state)
            rpr_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_ext = in_ext;
                    n_num = in_num;
                    n_den = in_den;
                    n_err = (in_den != '0) && (in_num == '0);
                    if (in_ext > r_eh0) n_einc = in_ext - r_eh0;
                    n_go  = 1'b1;
                    if ((in_den != '0) && (in_num != '0)) n_state = rpr_pkg::S_DRS;
                    else n_state = rpr_pkg::S_MUL1;
                end
            end
            rpr_pkg::S_DRS: begin
                if (alu_done) begin
                    n_rs    = quo[SW-1:0];
                    n_go    = 1'b1;
                    n_state = rpr_pkg::S_DIS;
                end
            end
            rpr_pkg::S_DIS: begin
                if (alu_done) begin
                    n_is    = quo[SW-1:0];
                    n_go    = 1'b1;
                    n_state = rpr_pkg::S_MUL1;
                end
            end
            rpr_pkg::S_MUL1: begin
                if (alu_done) begin
                    n_x1    = (res_hi > Cap4) ? Cap4[PW+2:0] : res_hi[PW+2:0];
                    n_go    = 1'b1;
                    n_state = rpr_pkg::S_MUL2;
                end
            end
            rpr_pkg::S_MUL2: begin
                if (alu_done) begin
                    n_main = adv_out;
                    if (adv_out > r_main) n_minc = adv_out - r_main;
                    n_go    = 1'b1;
                    n_state = rpr_pkg::S_MUL3;
                end
            end
            rpr_pkg::S_MUL3: begin
                if (alu_done) begin
                    n_pc = adv_out;
                    // keep the correction when the old check phase is zero
                    if (r_chk1 != '0) begin
                        n_go    = 1'b1;
                        n_state = rpr_pkg::S_DCOR;
                    end else begin
                        n_state = rpr_pkg::S_FIN;
                    end
                end
            end
            rpr_pkg::S_DCOR: begin
                if (alu_done) begin
                    if (quo > CorMax)      n_corr = CorMax[CW-1:0];
                    else if (quo < CorMin) n_corr = CorMin[CW-1:0];
                    else                   n_corr = quo[CW-1:0];
                    n_state = rpr_pkg::S_FIN;
                end
            end
            rpr_pkg::S_FIN: begin
                // hold until the output register is free
                if (!r_ov || i_m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_oph   = r_main;
                    n_oerr  = r_err;
                    n_chk1  = r_chk0;
                    n_chk0  = r_pc;
                    n_eh1   = r_eh0;
                    n_eh0   = r_ext;
                    n_state = rpr_pkg::S_IDLE;
                end
            end
            default: n_state = rpr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpr_pkg::S_IDLE;
            r_go    <= 1'b0;
            r_main  <= '0;
            r_chk0  <= '0;
            r_chk1  <= '0;
            r_eh0   <= '0;
            r_eh1   <= '0;
            r_einc  <= '0;
            r_minc  <= '0;
            r_corr  <= CW'(One);
            r_rs    <= SW'(One);
            r_is    <= SW'(One);
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            r_main  <= n_main;
            r_chk0  <= n_chk0;
            r_chk1  <= n_chk1;
            r_eh0   <= n_eh0;
            r_eh1   <= n_eh1;
            r_einc  <= n_einc;
            r_minc  <= n_minc;
            r_corr  <= n_corr;
            r_rs    <= n_rs;
            r_is    <= n_is;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ext  <= n_ext;
        r_pc   <= n_pc;
        r_x1   <= n_x1;
        r_num  <= n_num;
        r_den  <= n_den;
        r_err  <= n_err;
        r_oph  <= n_oph;
        r_oerr <= n_oerr;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = 24'(r_oph);
    assign o_m_axis_tuser  = r_oerr;

endmodule
`default_nettype wire
